@@ sv/tcw_pkg.sv @@
// Shared types and constants of the text console character writer.
`default_nettype none

package tcw_pkg;

  // Item function selector
  typedef enum logic [1:0] {
    FUNC_PUT   = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  // Control characters
  localparam logic [7:0] CH_BS = 8'h08;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  // Register map: bit 2 of paddr selects the register word
  localparam logic ADDR_TEXT_ATTR = 1'b0;
  localparam logic [7:0] TEXT_ATTR_RESET = 8'h0F;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;      // load the accepted item
    logic cursor_step;  // apply a put-character cursor move and cell write
    logic bs_write;     // write back a cell with its character byte cleared
    logic home;         // cursor to row 0, column 0
    logic row_dec;      // cursor up one row after a scroll
    logic sw_clr;       // restart the sweep index
    logic zero_step;    // write zero at the sweep index and advance
    logic copy_rd;      // read one row below the sweep index and advance
    logic out_load;     // move the result into the output register
  } tcw_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    func_t func;
    logic  is_bs;
    logic  col_zero;
    logic  row_last;
    logic  end_copy;
    logic  end_clr;
    logic  end_all;
    logic  out_free;
  } tcw_sts_t;

endpackage

`default_nettype wire

@@ sv/tcw_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/tcw_datapath.sv @@
// Datapath of the text console: cursor, cell store, sweep index and result register.
`default_nettype none

module tcw_datapath
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire tcw_cmd_t    cmd,
  output tcw_sts_t         sts,
  input  wire logic [1:0]  in_func,
  input  wire logic [7:0]  in_ch,
  input  wire logic [10:0] in_req,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  output logic      [7:0]  text_attr,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [10:0] cursor_pos,
  output logic      [7:0]  cell_char,
  output logic      [7:0]  cell_attr
);

  localparam int NCELLS = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(NCELLS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int EXT_W  = (ADDR_W > 11) ? ADDR_W : 11;

  // Item registers
  func_t       item_func;
  logic [7:0]  item_ch;
  logic [10:0] item_req;

  // Cursor and sweep state
  logic [COL_W-1:0]  cursor_col, col_next;
  logic [ROW_W-1:0]  cursor_row, row_next;
  logic [ADDR_W-1:0] sidx;
  logic              cp_pend;
  logic [ADDR_W-1:0] cp_addr;

  logic [ADDR_W-1:0] cur_idx;
  logic [ADDR_W-1:0] req_addr;
  logic              req_in_range;
  logic              char_we;
  logic [EXT_W-1:0]  pos_ext;

  // RAM ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [15:0]       ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [15:0]       ram_rdata;

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (NCELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Linear cursor index and read request decode
  assign cur_idx = ADDR_W'(cursor_row) * ADDR_W'(COLUMNS) + ADDR_W'(cursor_col);
  assign req_in_range = (32'(item_req) < NCELLS);
  assign req_addr = req_in_range ? ADDR_W'(item_req) : '0;
  assign pos_ext = EXT_W'(cur_idx);

  // Cursor update
  always_comb begin
    col_next = cursor_col;
    row_next = cursor_row;
    char_we  = 1'b0;
    if (cmd.home) begin
      col_next = '0;
      row_next = '0;
    end else if (cmd.row_dec) begin
      row_next = cursor_row - ROW_W'(1);
    end else if (cmd.cursor_step && item_func == FUNC_PUT) begin
      case (item_ch)
        CH_BS: begin
          if (cursor_col != '0) begin
            col_next = cursor_col - COL_W'(1);
          end
        end
        CH_CR: begin
          col_next = '0;
        end
        CH_LF: begin
          col_next = '0;
          row_next = cursor_row + ROW_W'(1);
        end
        default: begin
          char_we = 1'b1;
          if (cursor_col == COL_W'(COLUMNS - 1)) begin
            col_next = '0;
            row_next = cursor_row + ROW_W'(1);
          end else begin
            col_next = cursor_col + COL_W'(1);
          end
        end
      endcase
    end
  end

  // Cell store write and read address selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_idx;
    ram_wdata = '0;
    if (cp_pend) begin
      ram_we    = 1'b1;
      ram_waddr = cp_addr;
      ram_wdata = ram_rdata;
    end else if (cmd.zero_step) begin
      ram_we    = 1'b1;
      ram_waddr = sidx;
    end else if (char_we) begin
      ram_we    = 1'b1;
      ram_wdata = {text_attr, item_ch};
    end else if (cmd.bs_write) begin
      ram_we    = 1'b1;
      ram_wdata = {ram_rdata[15:8], 8'h00};
    end
    if (cmd.copy_rd) begin
      ram_raddr = sidx + ADDR_W'(COLUMNS);
    end else if (item_func == FUNC_READ) begin
      ram_raddr = req_addr;
    end else begin
      ram_raddr = cur_idx;
    end
  end

  // Hold item fields
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_func <= func_t'(in_func);
      item_ch   <= in_ch;
      item_req  <= in_req;
    end
    cp_addr <= sidx;
  end

  // Control registers: cursor, sweep, attribute, result
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
      sidx       <= '0;
      cp_pend    <= 1'b0;
      text_attr  <= TEXT_ATTR_RESET;
      out_valid  <= 1'b0;
    end else begin
      cursor_col <= col_next;
      cursor_row <= row_next;
      cp_pend    <= cmd.copy_rd;
      if (cmd.sw_clr) begin
        sidx <= '0;
      end else if (cmd.zero_step || cmd.copy_rd) begin
        sidx <= sidx + ADDR_W'(1);
      end
      if (cfg_we) begin
        text_attr <= cfg_wdata;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cursor_pos <= pos_ext[10:0];
      if (item_func == FUNC_READ && req_in_range) begin
        cell_char <= ram_rdata[7:0];
        cell_attr <= ram_rdata[15:8];
      end else begin
        cell_char <= '0;
        cell_attr <= '0;
      end
    end
  end

  // Status to controller
  assign sts.func     = item_func;
  assign sts.is_bs    = (item_ch == CH_BS);
  assign sts.col_zero = (cursor_col == '0);
  assign sts.row_last = (cursor_row == ROW_W'(ROWS - 1));
  assign sts.end_copy = (sidx == ADDR_W'((ROWS - 2) * COLUMNS - 1));
  assign sts.end_clr  = (sidx == ADDR_W'((ROWS - 1) * COLUMNS - 1));
  assign sts.end_all  = (sidx == ADDR_W'(NCELLS - 1));
  assign sts.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

@@ sv/tcw_ctrl.sv @@
// Controller state machine of the text console: sequences item work and store sweeps.
`default_nettype none

module tcw_ctrl
  import tcw_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire tcw_sts_t sts,
  output tcw_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_BS_RD,
    S_BS_WR,
    S_POST,
    S_SCR_COPY,
    S_SCR_WAIT,
    S_SCR_ZERO,
    S_CLR,
    S_DONE
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_INIT: begin
        cmd.zero_step = 1'b1;
        if (sts.end_all) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.func)
          FUNC_PUT: begin
            cmd.cursor_step = 1'b1;
            if (sts.is_bs && !sts.col_zero) begin
              state_next = S_BS_RD;
            end else begin
              state_next = S_POST;
            end
          end
          FUNC_CLEAR: begin
            cmd.sw_clr = 1'b1;
            state_next = S_CLR;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_BS_RD: begin
        state_next = S_BS_WR;
      end
      S_BS_WR: begin
        cmd.bs_write = 1'b1;
        state_next   = S_POST;
      end
      S_POST: begin
        if (sts.row_last) begin
          cmd.sw_clr = 1'b1;
          state_next = S_SCR_COPY;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SCR_COPY: begin
        cmd.copy_rd = 1'b1;
        if (sts.end_copy) begin
          state_next = S_SCR_WAIT;
        end
      end
      S_SCR_WAIT: begin
        cmd.row_dec = 1'b1;
        state_next  = S_SCR_ZERO;
      end
      S_SCR_ZERO: begin
        cmd.zero_step = 1'b1;
        if (sts.end_clr) begin
          state_next = S_DONE;
        end
      end
      S_CLR: begin
        cmd.zero_step = 1'b1;
        if (sts.end_clr) begin
          cmd.home   = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/text_console_char_writer.sv @@
// Top level of the text console character writer: stream ports, register port, core.
//
// Character-cell text console of ROWS x COLUMNS cells, each holding a character byte
// and an attribute byte, with a cursor. Every input item gives one result item carrying
// the linear cursor position after the item and, for a read, the addressed cell. One
// item is worked at a time; the next is accepted while a finished result still waits
// in the output register. A backspace that moves the cursor reads and then rewrites
// the cell it lands on. An item that pushes the cursor onto the last row scrolls the
// store through its single RAM port pair before its result is given; a clear-screen
// item walks (ROWS-1)*COLUMNS cells (1920 at defaults). After reset a clearing pass
// writes zero to all ROWS*COLUMNS cells (2000 at defaults) before the first item is
// accepted; register writes are taken during it. The attribute register sits at byte
// address 0.
`default_nettype none

module text_console_char_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [7:0] ch, [18:8] cell_req, rest zero
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] func
  // Result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata,   // [10:0] cursor_pos, [18:11] cell_char,
                                           // [26:19] cell_attr, rest zero
  // Register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  tcw_cmd_t    cmd;
  tcw_sts_t    sts;
  logic        cfg_we;
  logic [7:0]  text_attr;
  logic [10:0] cursor_pos;
  logic [7:0]  cell_char;
  logic [7:0]  cell_attr;

  // Register decode
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == ADDR_TEXT_ATTR);
  assign prdata = (paddr[2] == ADDR_TEXT_ATTR) ? {24'h000000, text_attr} : 32'h0;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_func    (s_axis_tuser),
    .in_ch      (s_axis_tdata[7:0]),
    .in_req     (s_axis_tdata[18:8]),
    .cfg_we     (cfg_we),
    .cfg_wdata  (pwdata[7:0]),
    .text_attr  (text_attr),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .cursor_pos (cursor_pos),
    .cell_char  (cell_char),
    .cell_attr  (cell_attr)
  );

  // Pack result item
  assign m_axis_tdata = {5'b00000, cell_attr, cell_char, cursor_pos};

endmodule

`default_nettype wire

@@ sim/text_console_char_writer_test.sv @@
// Self-checking testbench of the text console character writer: stream items against a predictor.
`default_nettype none

module text_console_char_writer_test;
  import tcw_pkg::*;

  localparam int COLS   = 80;
  localparam int NROWS  = 25;
  localparam int NCELLS = NROWS * COLS;

  // One result item as the block reports it
  typedef struct packed {
    logic [10:0] pos;
    logic [7:0]  chr;
    logic [7:0]  attr;
  } console_out_t;

  // One row of the directed table; typed rows carry their result, others use the predictor
  typedef struct packed {
    func_t        f;
    logic [7:0]   c;
    logic [10:0]  req;
    logic         typed;
    console_out_t out;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // [7:0] ch, [18:8] cell_req, rest zero
  logic [1:0]  s_axis_tuser = '0;   // [1:0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [10:0] cursor_pos, [18:11] cell_char, [26:19] cell_attr
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predicted console state
  logic [15:0] screen [NCELLS];
  int          cur_col;
  int          cur_row;
  logic [7:0]  cur_attr;

  console_out_t expected_q [$];
  console_out_t got_item;
  console_out_t want_item;
  int           fail_cnt = 0;
  int           burst_left = 0;
  bit           random_started = 1'b0;
  bit           hold_off = 1'b0;
  int unsigned  ready_tick = 0;
  logic         ready_next;

  dir_row_t dir_tab [23] = '{
    '{FUNC_READ,  8'h00, 11'd0,    1'b1, '{11'd0,  8'h00, 8'h00}},
    '{FUNC_READ,  8'h00, 11'd1999, 1'b1, '{11'd0,  8'h00, 8'h00}},
    '{FUNC_READ,  8'hFF, 11'd2047, 1'b1, '{11'd0,  8'h00, 8'h00}},
    '{FUNC_NOP,   8'hFF, 11'd2047, 1'b1, '{11'd0,  8'h00, 8'h00}},
    '{FUNC_PUT,   CH_BS, 11'd0,    1'b1, '{11'd0,  8'h00, 8'h00}},
    '{FUNC_PUT,   8'h41, 11'd0,    1'b1, '{11'd1,  8'h00, 8'h00}},
    '{FUNC_PUT,   8'hFF, 11'd2047, 1'b1, '{11'd2,  8'h00, 8'h00}},
    '{FUNC_PUT,   8'h00, 11'd0,    1'b1, '{11'd3,  8'h00, 8'h00}},
    '{FUNC_READ,  8'h00, 11'd0,    1'b1, '{11'd3,  8'h41, 8'h0F}},
    '{FUNC_READ,  8'h00, 11'd1,    1'b1, '{11'd3,  8'hFF, 8'h0F}},
    '{FUNC_PUT,   CH_BS, 11'd0,    1'b0, '0},
    '{FUNC_PUT,   CH_BS, 11'd0,    1'b0, '0},
    '{FUNC_READ,  8'h00, 11'd1,    1'b0, '0},
    '{FUNC_PUT,   CH_CR, 11'd0,    1'b1, '{11'd0,  8'h00, 8'h00}},
    '{FUNC_PUT,   CH_LF, 11'd0,    1'b1, '{11'd80, 8'h00, 8'h00}},
    '{FUNC_PUT,   8'h7E, 11'd0,    1'b0, '0},
    '{FUNC_READ,  8'h00, 11'd80,   1'b0, '0},
    '{FUNC_CLEAR, 8'hFF, 11'd2047, 1'b1, '{11'd0,  8'h00, 8'h00}},
    '{FUNC_READ,  8'h00, 11'd80,   1'b1, '{11'd0,  8'h00, 8'h00}},
    '{FUNC_READ,  8'h00, 11'd0,    1'b1, '{11'd0,  8'h00, 8'h00}},
    '{FUNC_READ,  8'h00, 11'd1920, 1'b1, '{11'd0,  8'h00, 8'h00}},
    '{FUNC_PUT,   8'h80, 11'd0,    1'b0, '0},
    '{FUNC_READ,  8'h00, 11'd0,    1'b0, '0}
  };

  text_console_char_writer #(
    .COLUMNS(COLS),
    .ROWS   (NROWS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Zero a range of whole rows in the predicted store
  function automatic void blank_rows(int first, int last);
    for (int i = first * COLS; i < last * COLS && i < NCELLS; i++) begin
      screen[i] = 16'h0000;
    end
  endfunction

  // Apply one item to the predicted console and return its result
  function automatic console_out_t console_step(func_t f, logic [7:0] c, logic [10:0] req);
    console_out_t o;
    int idx;
    o = '0;
    case (f)
      FUNC_PUT: begin
        if (c == CH_BS) begin
          if (cur_col > 0) begin
            cur_col--;
            idx = cur_row * COLS + cur_col;
            if (idx < NCELLS) screen[idx][7:0] = 8'h00;
          end
        end else if (c == CH_CR) begin
          cur_col = 0;
        end else if (c == CH_LF) begin
          cur_col = 0;
          cur_row++;
        end else begin
          idx = cur_row * COLS + cur_col;
          if (idx < NCELLS) screen[idx] = {cur_attr, c};
          cur_col++;
        end
        if (cur_col >= COLS) begin
          cur_col = 0;
          cur_row++;
        end
        // Scroll the used rows up once the cursor lands on the last row
        if (cur_row >= NROWS - 1) begin
          for (int i = 0; i < (NROWS - 1) * COLS; i++) begin
            screen[i] = screen[i + COLS];
          end
          blank_rows(NROWS - 2, NROWS - 1);
          if (cur_row == 0) cur_col = 0;
          else cur_row--;
        end
      end
      FUNC_CLEAR: begin
        blank_rows(0, NROWS - 1);
        cur_col = 0;
        cur_row = 0;
      end
      FUNC_READ: begin
        if (req < NCELLS) begin
          o.chr  = screen[req][7:0];
          o.attr = screen[req][15:8];
        end
      end
      default: ;
    endcase
    o.pos = 11'(cur_row * COLS + cur_col);
    return o;
  endfunction

  // Offer one item, wait for accept, queue its result, then maybe open a gap
  task automatic send_item(func_t f, logic [7:0] c, logic [10:0] req, logic typed,
                           console_out_t typed_out);
    console_out_t p;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, req, c};
    s_axis_tuser  <= f;
    do @(posedge clk); while (!s_axis_tready);
    p = console_step(f, c, req);
    expected_q.push_back(typed ? typed_out : p);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  // Drop valid and wait until every queued result has come back
  task automatic drain_items();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Write the attribute register, then read it back in a back-to-back transfer
  task automatic set_text_attr(logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {ADDR_TEXT_ATTR, 2'b00};
    pwdata  <= {24'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cur_attr = v;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {24'h0, v}) begin
      fail_cnt++;
      if (fail_cnt <= 10) $display("text_attr readback: expected %h, got %h", v, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Receive results, check against the oldest expectation, and pattern the ready line
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_item = '{m_axis_tdata[10:0], m_axis_tdata[18:11], m_axis_tdata[26:19]};
        if (expected_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) $display("result with none pending: pos %0d char %h attr %h",
                                       got_item.pos, got_item.chr, got_item.attr);
        end else begin
          want_item = expected_q.pop_front();
          if (got_item.pos !== want_item.pos || got_item.chr !== want_item.chr ||
              got_item.attr !== want_item.attr) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("result mismatch: expected pos %0d char %h attr %h, got pos %0d char %h attr %h",
                       want_item.pos, want_item.chr, want_item.attr,
                       got_item.pos, got_item.chr, got_item.attr);
          end
        end
      end
      ready_tick++;
      case (ready_tick[8:7])
        2'd0:    ready_next = 1'b1;
        2'd1:    ready_next = $urandom_range(0, 1);
        2'd2:    ready_next = ($urandom_range(0, 3) == 0);
        default: ready_next = ($urandom_range(0, 4) != 0);
      endcase
      m_axis_tready <= !hold_off && ready_next;
    end
  end

  // Hold the receiver off for a long stretch early in the random part
  initial begin
    wait (random_started);
    repeat (40) @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Stop a hung run
  initial begin
    #50_000_000;
    $display("[text_console_char_writer] ERROR");
    $finish;
  end

  initial begin : main
    logic [7:0]   phase_attr [4];
    int           phase_len [4];
    int           phase_lf [4];
    int           r;
    int           base;
    int           pick;
    int           t_lf;
    logic [7:0]   c;
    logic [10:0]  req;
    func_t        f;
    phase_attr = '{8'h00, 8'hFF, 8'h00, 8'h00};
    phase_len  = '{120, 120, 130, 110};
    phase_lf   = '{20, 8, 12, 12};
    foreach (screen[i]) screen[i] = 16'h0000;
    cur_col  = 0;
    cur_row  = 0;
    cur_attr = TEXT_ATTR_RESET;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset attribute
    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].f, dir_tab[i].c, dir_tab[i].req, dir_tab[i].typed, dir_tab[i].out);
    end
    drain_items();
    random_started = 1'b1;

    // Random part: mostly text lines with reads, some noise, a few clears
    for (int ph = 0; ph < 4; ph++) begin
      set_text_attr((ph < 2) ? phase_attr[ph] : 8'($urandom_range(0, 255)));
      t_lf = 150 + phase_lf[ph] * 10;
      for (int n = 0; n < phase_len[ph]; n++) begin
        r   = $urandom_range(0, 999);
        c   = 8'($urandom_range(0, 255));
        req = 11'($urandom_range(0, 2047));
        f   = FUNC_PUT;
        if (r < 4) begin
          f = FUNC_CLEAR;
        end else if (r < 30) begin
          f = FUNC_NOP;
        end else if (r < 150) begin
          f    = FUNC_READ;
          pick = $urandom_range(0, 9);
          base = cur_row * COLS + cur_col;
          if (pick < 4) req = 11'(base - $urandom_range(0, (base < 160) ? base : 160));
          else if (pick < 7) req = 11'($urandom_range(0, NCELLS - 1));
          else if (pick == 7) req = 11'($urandom_range(NCELLS - COLS, NCELLS - 1));
        end else if (r < t_lf) begin
          c = CH_LF;
        end else if (r < t_lf + 70) begin
          c = CH_BS;
        end else if (r < t_lf + 100) begin
          c = CH_CR;
        end else if ($urandom_range(0, 4) != 0) begin
          c = 8'($urandom_range(8'h20, 8'h7E));
        end
        send_item(f, c, req, 1'b0, '0);
      end
      drain_items();
    end

    repeat (40) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("[text_console_char_writer] OK");
    end else begin
      $display("[text_console_char_writer] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
